// File: src/assert_macros.svh
// Assertion macros shared by the sound activity gate RTL.
// Depends on clk and arst_n being visible in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SAG_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define SAG_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define SAG_ASSERT(lbl, prop, msg)
`define SAG_NEVER(lbl, cond, msg)
`endif
`endif

// File: src/sag_pkg.sv
// Package for the sound activity gate: widths, codes, reset values and beat types.
// No dependencies.
`default_nettype none
package sag_pkg;
	localparam int FRAMES_W   = 9;
	localparam int ENERGY_W   = 31;
	localparam int LEVEL_W    = 16;
	localparam int INTERVAL_W = 20;
	localparam int QUIET_W    = 8;
	localparam int MODE_W     = 2;
	localparam int SAMPLES_W  = 21;
	localparam int SUM_W      = 48;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 20;
	localparam int TRIG_PROD_W  = LEVEL_W + 1 + FRAMES_W;
	localparam int QUIET_PROD_W = LEVEL_W + SAMPLES_W;

	localparam int BLOCK_FRAMES_DEF = 256;

	localparam logic [MODE_W-1:0] MODE_IDLE   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_GATHER = 2'd1;
	localparam logic [MODE_W-1:0] MODE_STREAM = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_LEVEL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SEND_INTERVAL = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SILENCE_LEVEL = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_QUIET_MAX     = 2'd3;

	localparam logic [LEVEL_W-1:0]    TRIGGER_LEVEL_RST = 16'd1000;
	localparam logic [INTERVAL_W-1:0] SEND_INTERVAL_RST = 20'd16000;
	localparam logic [LEVEL_W-1:0]    SILENCE_LEVEL_RST = 16'd500;
	localparam logic [QUIET_W-1:0]    QUIET_MAX_RST     = 8'd3;

	typedef struct packed {
		logic [FRAMES_W-1:0] frame_count;
		logic [ENERGY_W-1:0] energy_left;
		logic [ENERGY_W-1:0] energy_right;
		logic [ENERGY_W-1:0] energy_back;
		logic                muted;
	} item_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic              direction_restart;
		logic              direction_feed;
		logic              send_now;
		logic              went_idle;
	} result_t;

	typedef struct packed {
		logic [LEVEL_W-1:0]    trigger_level;
		logic [INTERVAL_W-1:0] send_interval;
		logic [LEVEL_W-1:0]    silence_level;
		logic [QUIET_W-1:0]    quiet_intervals_max;
	} cfg_t;

	typedef struct packed {
		logic [MODE_W-1:0]    mode;
		logic [SAMPLES_W-1:0] samples;
		logic [SUM_W-1:0]     sum;
		logic [QUIET_W-1:0]   quiet;
	} gate_state_t;
endpackage
`default_nettype wire

// File: src/sag_cfg.sv
// Configuration register file of the sound activity gate.
// Depends on sag_pkg.
`default_nettype none
module sag_cfg (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [sag_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [sag_pkg::CFG_DATA_W-1:0]  cfg_data,
	output sag_pkg::cfg_t                        cfg
);
	import sag_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.trigger_level       <= TRIGGER_LEVEL_RST;
			cfg_q.send_interval       <= SEND_INTERVAL_RST;
			cfg_q.silence_level       <= SILENCE_LEVEL_RST;
			cfg_q.quiet_intervals_max <= QUIET_MAX_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_TRIGGER_LEVEL: cfg_q.trigger_level <= cfg_data[LEVEL_W-1:0];
				CFG_SEND_INTERVAL: cfg_q.send_interval <= cfg_data[INTERVAL_W-1:0];
				CFG_SILENCE_LEVEL: cfg_q.silence_level <= cfg_data[LEVEL_W-1:0];
				CFG_QUIET_MAX:     cfg_q.quiet_intervals_max <= cfg_data[QUIET_W-1:0];
			endcase
		end
	end
endmodule
`default_nettype wire

// File: src/sag_step.sv
// Single-pass update of the gate: trigger test, accumulation, send and hangover.
// Depends on sag_pkg.
`default_nettype none
module sag_step #(
	parameter int BLOCK_FRAMES = sag_pkg::BLOCK_FRAMES_DEF
) (
	input  wire sag_pkg::item_t       item,
	input  wire sag_pkg::gate_state_t cur,
	input  wire sag_pkg::cfg_t        cfg,
	output sag_pkg::gate_state_t      nxt,
	output sag_pkg::result_t          res
);
	import sag_pkg::*;

	logic [FRAMES_W-1:0]     frames;
	logic [ENERGY_W-1:0]     peak_lr;
	logic [ENERGY_W-1:0]     peak;
	logic [LEVEL_W:0]        level_p1;
	logic [TRIG_PROD_W-1:0]  trig_prod;
	logic                    trigger;
	logic [SUM_W:0]          sum_add;
	logic [SUM_W-1:0]        sum_sat;
	logic [SAMPLES_W-1:0]    samples_add;
	logic [QUIET_PROD_W-1:0] quiet_prod;
	logic                    quiet;
	logic                    send_due;
	logic [QUIET_W-1:0]      quiet_inc;

	always_comb begin
		// clamp to the block size
		frames = (32'(item.frame_count) > 32'(BLOCK_FRAMES)) ?
			FRAMES_W'(BLOCK_FRAMES) : item.frame_count;
		peak_lr = (item.energy_right > item.energy_left) ? item.energy_right : item.energy_left;
		peak = (item.energy_back > peak_lr) ? item.energy_back : peak_lr;

		// floor(peak / frames) > level  <=>  peak >= (level + 1) * frames
		level_p1 = (LEVEL_W+1)'(cfg.trigger_level) + (LEVEL_W+1)'(1);
		trig_prod = TRIG_PROD_W'(level_p1) * TRIG_PROD_W'(frames);
		trigger = (frames != '0) && (peak >= ENERGY_W'(trig_prod));

		sum_add = {1'b0, cur.sum} + (SUM_W+1)'(peak);
		sum_sat = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
		samples_add = cur.samples + SAMPLES_W'(frames);
		send_due = samples_add >= SAMPLES_W'(cfg.send_interval);

		// floor(sum / n) < level  <=>  sum < level * n
		quiet_prod = QUIET_PROD_W'(cfg.silence_level) * QUIET_PROD_W'(samples_add);
		quiet = sum_sat < SUM_W'(quiet_prod);
		quiet_inc = (cur.quiet == {QUIET_W{1'b1}}) ? cur.quiet : cur.quiet + QUIET_W'(1);

		nxt = cur;
		res.direction_restart = 1'b0;
		res.direction_feed    = 1'b0;
		res.send_now          = 1'b0;
		res.went_idle         = 1'b0;

		if (!item.muted) begin
			if (cur.mode == MODE_IDLE) begin
				if (trigger) begin
					nxt.mode    = MODE_GATHER;
					nxt.samples = SAMPLES_W'(frames);
					nxt.sum     = SUM_W'(peak);
					res.direction_restart = 1'b1;
					res.direction_feed    = 1'b1;
				end
			end else begin
				res.direction_feed = 1'b1;
				nxt.sum     = sum_sat;
				nxt.samples = samples_add;
				if (send_due) begin
					res.send_now = 1'b1;
					nxt.mode    = MODE_STREAM;
					nxt.samples = '0;
					nxt.sum     = '0;
					if (quiet) begin
						nxt.quiet = quiet_inc;
						if (quiet_inc >= cfg.quiet_intervals_max) begin
							nxt.mode  = MODE_IDLE;
							nxt.quiet = '0;
							res.went_idle = 1'b1;
						end
					end else begin
						nxt.quiet = '0;
					end
				end
			end
		end
		res.mode = nxt.mode;
	end
endmodule
`default_nettype wire

// File: src/sound_activity_gate.sv
// Sound activity gate: an accepted item reaches its result beat through the input
// register, the update logic and the result register, which form the only path;
// one item per cycle sustained while results are taken. A stalled result holds the
// input register, which then holds off new items. Reset clears mode, counters, sum
// and configuration to their defaults.
// Depends on sag_pkg, sag_cfg, sag_step and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module sound_activity_gate #(
	parameter int BLOCK_FRAMES = sag_pkg::BLOCK_FRAMES_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            item_valid,
	output logic                                 item_ready,
	input  wire sag_pkg::item_t                  item,
	output logic                                 res_valid,
	input  wire logic                            res_ready,
	output sag_pkg::result_t                     res,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [sag_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [sag_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import sag_pkg::*;

	cfg_t        cfg;
	item_t       item_s1;
	logic        valid_s1;
	gate_state_t state_q;
	gate_state_t state_nxt;
	result_t     res_nxt;
	result_t     res_q;
	logic        res_valid_q;
	logic        advance;

	sag_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	sag_step #(
		.BLOCK_FRAMES (BLOCK_FRAMES)
	) u_step (
		.item (item_s1),
		.cur  (state_q),
		.cfg  (cfg),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	assign advance    = valid_s1 && (!res_valid_q || res_ready);
	assign item_ready = !valid_s1 || advance;
	assign res_valid  = res_valid_q;
	assign res        = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
			state_q     <= '{mode: MODE_IDLE, samples: '0, sum: '0, quiet: '0};
		end else begin
			valid_s1    <= (item_valid && item_ready) || (valid_s1 && !advance);
			res_valid_q <= advance || (res_valid_q && !res_ready);
			if (advance) begin
				state_q <= state_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
		if (advance) begin
			res_q <= res_nxt;
		end
	end

	`SAG_ASSERT(a_idle_after_send, (res_valid && res.went_idle) |-> (res.send_now && res.mode == MODE_IDLE), "went_idle without send or idle mode")
	`SAG_ASSERT(a_restart_gathers, (res_valid && res.direction_restart) |-> (res.direction_feed && res.mode == MODE_GATHER), "restart beat not gathering")
	`SAG_ASSERT(a_idle_holds, (advance && state_q.mode == MODE_IDLE && !res_nxt.direction_restart) |=> (state_q.mode == MODE_IDLE), "left idle without trigger")
	`SAG_NEVER(a_muted_quiet, advance && item_s1.muted && (res_nxt.direction_feed || res_nxt.send_now), "muted block raised a strobe")
endmodule
`default_nettype wire
